// File: design/b64d_pkg.sv
package b64d_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_LENGTH  = 2'd2
  } status_t;

  // One decoded quad, or a length error, on its way to the output side.
  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  count;
    logic        last;
    status_t     status;
  } job_t;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [5:0] OFS_LOWER  = 6'd26;
  localparam logic [5:0] OFS_DIGIT  = 6'd52;
  localparam logic [5:0] VAL_PLUS   = 6'd62;
  localparam logic [5:0] VAL_SLASH  = 6'd63;

  // Maps one character to {valid, sextet}; the padding character is not
  // valid here and is handled by the caller.
  function automatic logic [6:0] map_sextet(input logic [7:0] ch);
    logic [7:0] diff;
    logic [6:0] res;
    diff = 8'h00;
    res  = 7'h00;
    case (ch) inside
      [8'h41:8'h5A]: begin
        diff = ch - 8'h41;
        res  = {1'b1, diff[5:0]};
      end
      [8'h61:8'h7A]: begin
        diff = ch - 8'h61;
        res  = {1'b1, diff[5:0] + OFS_LOWER};
      end
      [8'h30:8'h39]: begin
        diff = ch - 8'h30;
        res  = {1'b1, diff[5:0] + OFS_DIGIT};
      end
      CHAR_PLUS:  res = {1'b1, VAL_PLUS};
      CHAR_SLASH: res = {1'b1, VAL_SLASH};
      default:    res = 7'h00;
    endcase
    return res;
  endfunction

endpackage

// File: design/b64d_front.sv
module b64d_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     char_in,
  input  logic           is_last,
  output logic           push,
  output b64d_pkg::job_t push_job,
  input  logic           queue_full
);
  import b64d_pkg::*;

  logic [1:0]  qpos_r, qpos_nxt;
  logic [17:0] acc_r, acc_nxt;
  logic        inv_r, inv_nxt;
  logic        prev_pad_r, prev_pad_nxt;

  logic        accept;
  logic        pad;
  logic [6:0]  mapped;
  logic        cur_invalid;
  logic [5:0]  sextet;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // Classify the incoming character.
  always_comb begin
    pad         = (char_in == CHAR_PAD);
    mapped      = map_sextet(char_in);
    cur_invalid = !pad && !mapped[6];
    sextet      = mapped[6] ? mapped[5:0] : 6'd0;
  end

  // Quad assembly and job generation.
  always_comb begin
    qpos_nxt        = qpos_r;
    acc_nxt         = acc_r;
    inv_nxt         = inv_r;
    prev_pad_nxt    = prev_pad_r;
    push            = 1'b0;
    push_job.triple = {acc_r, sextet};
    push_job.count  = 2'd3;
    push_job.last   = is_last;
    push_job.status = (inv_r || cur_invalid) ? ST_INVALID : ST_OK;
    if (qpos_r != 2'd3) begin
      // A quad that stops short on the final character is a length error.
      push_job.triple = 24'h000000;
      push_job.count  = 2'd1;
      push_job.status = ST_LENGTH;
    end else if (is_last && pad) begin
      push_job.count = prev_pad_r ? 2'd1 : 2'd2;
    end
    if (accept) begin
      inv_nxt      = inv_r || cur_invalid;
      prev_pad_nxt = pad;
      if (qpos_r != 2'd3) begin
        acc_nxt  = {acc_r[11:0], sextet};
        qpos_nxt = qpos_r + 2'd1;
        push     = is_last;
      end else begin
        acc_nxt  = 18'h00000;
        qpos_nxt = 2'd0;
        push     = 1'b1;
      end
      if (is_last) begin
        qpos_nxt     = 2'd0;
        acc_nxt      = 18'h00000;
        inv_nxt      = 1'b0;
        prev_pad_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qpos_r     <= 2'd0;
      acc_r      <= 18'h00000;
      inv_r      <= 1'b0;
      prev_pad_r <= 1'b0;
    end else begin
      qpos_r     <= qpos_nxt;
      acc_r      <= acc_nxt;
      inv_r      <= inv_nxt;
      prev_pad_r <= prev_pad_nxt;
    end
  end

endmodule

// File: design/b64d_queue.sv
module b64d_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64d_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output b64d_pkg::job_t pop_job
);
  import b64d_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = slots_r[rd_ptr_r];

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("job queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("job queue fill level out of range");
`endif

endmodule

// File: design/b64d_back.sv
module b64d_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           queue_empty,
  input  b64d_pkg::job_t queue_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     data_byte,
  output logic           last_of_run,
  output logic [1:0]     status
);
  import b64d_pkg::*;

  job_t       cur_r, cur_nxt;
  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       final_byte;
  logic       done;
  logic [7:0] sel_byte;

  assign final_byte = (idx_r == cur_r.count - 2'd1);
  assign done       = valid_r && out_ready && final_byte;
  assign pop        = !queue_empty && (!valid_r || done);

  // Byte selection, most significant first; errors force zero data.
  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = cur_r.triple[23:16];
      2'd1:    sel_byte = cur_r.triple[15:8];
      2'd2:    sel_byte = cur_r.triple[7:0];
      default: sel_byte = 8'h00;
    endcase
    out_valid   = valid_r;
    data_byte   = (cur_r.status == ST_OK) ? sel_byte : 8'h00;
    last_of_run = cur_r.last && final_byte;
    status      = cur_r.status;
  end

  // Step through the bytes of the current job, reloading without a gap.
  always_comb begin
    cur_nxt   = cur_r;
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (valid_r && out_ready && !final_byte) begin
      idx_nxt = idx_r + 2'd1;
    end
    if (done) begin
      valid_nxt = 1'b0;
    end
    if (pop) begin
      cur_nxt   = queue_job;
      valid_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (cur_r.count != 2'd0 && idx_r < cur_r.count))
    else $error("byte index beyond the job's byte count");
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status != ST_OK) |-> data_byte == 8'h00)
    else $error("data byte not zero on an error result");
  a_length_single: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && cur_r.status == ST_LENGTH) |-> (cur_r.count == 2'd1 && cur_r.last))
    else $error("length error job is not a single final result");
`endif

endmodule

// File: design/base64_stream_decoder_core.sv
// Streaming Base64 decoder, standard alphabet.
// Input channel in_*: one character per transaction, in_tdata[7:0] holds the
// character and in_tlast marks the final character of a message.
// Output channel out_*: one decoded byte per transaction in out_tdata[7:0],
// out_tlast on the final result of a message and out_tuser holding the status
// (0 ok, 1 invalid character seen, 2 length not a multiple of four). Bytes are
// zero whenever the status is not ok.
// Throughput: one character per cycle sustained while the queue has room; a
// complete quad yields up to three bytes, which the output side sends at one
// per cycle while out_tready is high. The first byte of a quad passes from the
// quad assembler through the job queue into the byte sequencer's output
// register before it appears.
// Reset clears the quad state, empties the queue and drops the output valid
// flag; no message is in progress afterwards.
// When the receiver stalls, the output holds its byte; the queue absorbs
// QUEUE_DEPTH decoded quads before in_tready falls.
module base64_stream_decoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_byte
  output logic       out_tlast,
  output logic [1:0] out_tuser   // [1:0] status
);
  import b64d_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t pop_job;

  // Character classification and quad assembly.
  b64d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .char_in    (in_tdata),
    .is_last    (in_tlast),
    .push       (push),
    .push_job   (push_job),
    .queue_full (full)
  );

  // Decoded quads waiting for the output side.
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .pop_job  (pop_job)
  );

  // Byte sequencer driving the output channel.
  b64d_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_empty (empty),
    .queue_job   (pop_job),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .data_byte   (out_tdata),
    .last_of_run (out_tlast),
    .status      (out_tuser)
  );

endmodule
